// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TKST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define TKST_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/core/tkst_pkg.sv
// types and constants of the sorted top-k table
// no dependencies
package tkst_pkg;

  localparam int TABLE_DEPTH_DEF = 10;
  localparam int COUNT_W         = 5;
  localparam int INDEX_W         = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [31:0]        tag;
  } entry_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] score_in;
    logic [31:0]        tag_in;
    logic [INDEX_W-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic               accepted;
    logic [INDEX_W-1:0] insert_position;
    logic [COUNT_W-1:0] entry_count;
    logic               read_valid;
    logic signed [31:0] read_score;
    logic [31:0]        read_tag;
  } out_word_t;

endpackage

// File: rtl/core/tkst_mem.sv
// entry memory: one write port, one read port, registered read data
// depends on tkst_pkg
module tkst_mem #(
  parameter int DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  tkst_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output tkst_pkg::entry_t rd_data
);

  tkst_pkg::entry_t mem [DEPTH];
  tkst_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/tkst_ctrl.sv
// sequencer for insert and read words: an insert walks the table from the bottom,
// moving one entry per cycle through the entry memory
// depends on tkst_pkg
module tkst_ctrl #(
  parameter int DEPTH = tkst_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tkst_pkg::in_word_t  in_data,
  output logic                out_valid,
  output tkst_pkg::out_word_t out_data,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output tkst_pkg::entry_t    wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  tkst_pkg::entry_t    rd_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW-1:0] PREV_IDX = AW'((DEPTH > 1) ? DEPTH - 2 : 0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_PLACE,
    ST_READ
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       hole_r, hole_nxt;
  tkst_pkg::entry_t    new_r, new_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic                out_valid_r, out_valid_nxt;
  tkst_pkg::out_word_t out_r, out_nxt;

  logic                above;
  logic                idx_ok;
  logic                cnt_full;
  logic [CW-1:0]       cnt_inc;

  assign above    = new_r.score > rd_data.score;
  assign idx_ok   = tkst_pkg::COUNT_W'(in_data.read_index) < tkst_pkg::COUNT_W'(cnt_r);
  assign cnt_full = cnt_r == FULL_CNT;
  assign cnt_inc  = cnt_full ? cnt_r : cnt_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hole_nxt      = hole_r;
    new_nxt       = new_r;
    rvalid_nxt    = rvalid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = hole_r;
    wr_data       = new_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          new_nxt.score = in_data.score_in;
          new_nxt.tag   = in_data.tag_in;
          if (in_data.operation == tkst_pkg::OP_READ) begin
            rvalid_nxt = idx_ok;
            rd_en      = 1'b1;
            rd_addr    = idx_ok ? AW'(in_data.read_index) : '0;
            state_nxt  = ST_READ;
          end else if (cnt_full) begin
            rd_en     = 1'b1;
            rd_addr   = LAST_IDX;
            state_nxt = ST_LAST;
          end else if (cnt_r == '0) begin
            hole_nxt  = '0;
            state_nxt = ST_PLACE;
          end else begin
            hole_nxt  = AW'(cnt_r);
            rd_en     = 1'b1;
            rd_addr   = AW'(cnt_r - CW'(1));
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LAST: begin
        if (!above) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.entry_count = tkst_pkg::COUNT_W'(cnt_r);
          state_nxt     = ST_IDLE;
        end else if (DEPTH == 1) begin
          hole_nxt  = '0;
          state_nxt = ST_PLACE;
        end else begin
          hole_nxt  = LAST_IDX;
          rd_en     = 1'b1;
          rd_addr   = PREV_IDX;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        wr_en = 1'b1;
        if (above) begin
          wr_data = rd_data;
          if (hole_r == AW'(1)) begin
            hole_nxt  = '0;
            state_nxt = ST_PLACE;
          end else begin
            hole_nxt  = hole_r - AW'(1);
            rd_en     = 1'b1;
            rd_addr   = hole_r - AW'(2);
          end
        end else begin
          cnt_nxt       = cnt_inc;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.accepted        = 1'b1;
          out_nxt.insert_position = tkst_pkg::INDEX_W'(hole_r);
          out_nxt.entry_count     = tkst_pkg::COUNT_W'(cnt_inc);
          state_nxt     = ST_IDLE;
        end
      end
      ST_PLACE: begin
        wr_en         = 1'b1;
        cnt_nxt       = cnt_inc;
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.accepted        = 1'b1;
        out_nxt.insert_position = tkst_pkg::INDEX_W'(hole_r);
        out_nxt.entry_count     = tkst_pkg::COUNT_W'(cnt_inc);
        state_nxt     = ST_IDLE;
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        out_nxt.entry_count = tkst_pkg::COUNT_W'(cnt_r);
        out_nxt.read_valid  = rvalid_r;
        if (rvalid_r) begin
          out_nxt.read_score = rd_data.score;
          out_nxt.read_tag   = rd_data.tag;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hole_r   <= hole_nxt;
    new_r    <= new_nxt;
    rvalid_r <= rvalid_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/top_k_sorted_insert_table.sv
// top level of the sorted top-k table: sequencer plus entry memory
// depends on tkst_pkg, tkst_ctrl, tkst_mem
//
// A word is taken when start is high and busy is low; every word gives one
// result word on out_data, marked by out_valid for one cycle, and the
// receiver cannot hold it off. A read keeps busy high while the entry is
// read. An insert keeps busy high while it moves entries down one at a time,
// checking the last entry first when the table is full; a rejected insert
// ends after that check. The strobe comes in the first cycle with busy
// low again, and a new word may be taken in that same cycle. The entry
// memory, with one read port and one write port, moves one entry per cycle.
module top_k_sorted_insert_table #(
  parameter int TABLE_DEPTH = tkst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tkst_pkg::in_word_t  in_data,
  output logic                out_valid,
  output tkst_pkg::out_word_t out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  tkst_pkg::entry_t wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  tkst_pkg::entry_t rd_data;

  tkst_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  tkst_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/core/tkst_chk.sv
// port checker for the sorted top-k table, bound to the top level
// depends on tkst_pkg, assert_macros.svh, top_k_sorted_insert_table
`include "assert_macros.svh"

module tkst_chk #(
  parameter int DEPTH = tkst_pkg::TABLE_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input tkst_pkg::out_word_t out_data,
  input logic                out_valid
);

  localparam logic [tkst_pkg::COUNT_W-1:0] MAX_CNT = tkst_pkg::COUNT_W'(DEPTH);

  `TKST_ASSERT(a_take_busy, clk, rst_n, (start && !busy) |=> busy, "word taken without busy")
  `TKST_ASSERT(a_no_burst, clk, rst_n, out_valid |=> !out_valid, "result strobes back to back")
  `TKST_NEVER(a_count_max, clk, rst_n, out_valid && (out_data.entry_count > MAX_CNT), "count above depth")
  `TKST_NEVER(a_kind_mix, clk, rst_n, out_valid && out_data.accepted && out_data.read_valid, "insert and read flags together")
  `TKST_NEVER(a_acc_empty, clk, rst_n, out_valid && out_data.accepted && (out_data.entry_count == '0), "accepted insert with empty table")

endmodule

bind top_k_sorted_insert_table tkst_chk #(
  .DEPTH (TABLE_DEPTH)
) u_tkst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);

// File: test/tb_top_k_sorted_insert_table.sv
// self-checking testbench for top_k_sorted_insert_table: directed table, then random words
// keeps its own sorted score table to predict result words not given in the directed table; depends on tkst_pkg
module tb_top_k_sorted_insert_table;
  import tkst_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_WORDS = 1450;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_data;

  logic signed [31:0] tbl_score [DEPTH];
  logic [31:0]        tbl_tag [DEPTH];
  int                 tbl_count = 0;

  out_word_t pending_results [$];
  stim_row_t stim_rows [$];
  int        mismatch_count = 0;
  int        results_seen = 0;

  top_k_sorted_insert_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // sorted insert or read, equal scores land below existing ones
  function automatic out_word_t table_apply(in_word_t w);
    out_word_t r;
    int        pos;
    int        lim;
    int        i;
    bit        full;
    r = '0;
    if (w.operation == OP_INSERT) begin
      full = (tbl_count >= DEPTH);
      if (!full || w.score_in > tbl_score[DEPTH-1]) begin
        pos = full ? DEPTH - 1 : tbl_count;
        lim = pos;
        for (i = 0; i < tbl_count; i++) begin
          if (w.score_in > tbl_score[i]) begin
            pos = i;
            break;
          end
        end
        for (i = lim; i > pos; i--) begin
          tbl_score[i] = tbl_score[i-1];
          tbl_tag[i] = tbl_tag[i-1];
        end
        tbl_score[pos] = w.score_in;
        tbl_tag[pos] = w.tag_in;
        if (!full) tbl_count++;
        r.accepted = 1'b1;
        r.insert_position = pos[INDEX_W-1:0];
      end
    end else if (int'(w.read_index) < tbl_count) begin
      r.read_valid = 1'b1;
      r.read_score = tbl_score[w.read_index];
      r.read_tag = tbl_tag[w.read_index];
    end
    r.entry_count = tbl_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic out_word_t exp_word(bit acc, int pos, int cnt, bit rv,
                                         logic signed [31:0] rs, logic [31:0] rt);
    out_word_t r;
    r.accepted = acc;
    r.insert_position = pos[INDEX_W-1:0];
    r.entry_count = cnt[COUNT_W-1:0];
    r.read_valid = rv;
    r.read_score = rs;
    r.read_tag = rt;
    return r;
  endfunction

  function automatic stim_row_t row(op_t op, logic signed [31:0] s, logic [31:0] t,
                                    int idx, bit typed, out_word_t want);
    stim_row_t r;
    r.w.operation = op;
    r.w.score_in = s;
    r.w.tag_in = t;
    r.w.read_index = idx[INDEX_W-1:0];
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.operation = ($urandom_range(99) < 55) ? OP_INSERT : OP_READ;
    w.tag_in = $urandom;
    w.read_index = INDEX_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 30 || (pick >= 60 && tbl_count == 0)) begin
      w.score_in = $urandom;
    end else if (pick < 50) begin
      w.score_in = 32'($urandom_range(16)) - 32'd8;
    end else if (pick < 60) begin
      w.score_in = $urandom_range(1) ? SCORE_MAX : SCORE_MIN;
    end else begin
      // near the bottom entry: accepts, rejects and ties with the last one
      w.score_in = tbl_score[tbl_count-1] + 32'($urandom_range(6)) - 32'd3;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch on %s at result %0d: got %h, want %h", what, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t want, bit may_idle);
    out_word_t pred;
    if (may_idle && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = table_apply(w);
    pending_results.push_back(typed ? want : pred);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.accepted !== want.accepted)
          report_mismatch("accepted", 32'(out_data.accepted), 32'(want.accepted));
        if (out_data.insert_position !== want.insert_position)
          report_mismatch("insert_position", 32'(out_data.insert_position),
                          32'(want.insert_position));
        if (out_data.entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
        if (out_data.read_valid !== want.read_valid)
          report_mismatch("read_valid", 32'(out_data.read_valid), 32'(want.read_valid));
        if (out_data.read_score !== want.read_score)
          report_mismatch("read_score", out_data.read_score, want.read_score);
        if (out_data.read_tag !== want.read_tag)
          report_mismatch("read_tag", out_data.read_tag, want.read_tag);
      end
      results_seen++;
    end
  end

  initial begin
    out_word_t none;
    out_word_t rejected;
    none = '0;
    rejected = exp_word(0, 0, DEPTH, 0, 0, 0);

    // empty table, then extremes, ties, fill, rejects at the bottom
    stim_rows.push_back(row(OP_READ, SCORE_MAX, 32'hffff_ffff, 0, 1, exp_word(0, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(OP_READ, SCORE_MIN, 32'h1234_5678, 15, 1, exp_word(0, 0, 0, 0, 0, 0)));
    stim_rows.push_back(row(OP_INSERT, SCORE_MAX, 32'hffff_ffff, 15, 1,
                            exp_word(1, 0, 1, 0, 0, 0)));
    stim_rows.push_back(row(OP_INSERT, SCORE_MIN, 32'h0, 0, 1, exp_word(1, 1, 2, 0, 0, 0)));
    stim_rows.push_back(row(OP_READ, 32'sh5a5a_5a5a, 32'ha5a5_a5a5, 0, 1,
                            exp_word(0, 0, 2, 1, SCORE_MAX, 32'hffff_ffff)));
    stim_rows.push_back(row(OP_READ, 32'sh0, 32'h0, 1, 1, exp_word(0, 0, 2, 1, SCORE_MIN, 32'h0)));
    stim_rows.push_back(row(OP_READ, 32'sh0, 32'h0, 2, 1, exp_word(0, 0, 2, 0, 0, 0)));
    stim_rows.push_back(row(OP_INSERT, 32'sd100, 32'h0000_00a1, 7, 0, none));
    stim_rows.push_back(row(OP_INSERT, 32'sd100, 32'h0000_00a2, 8, 0, none));
    stim_rows.push_back(row(OP_INSERT, -32'sd1, 32'h0000_00a3, 0, 0, none));
    stim_rows.push_back(row(OP_INSERT, 32'sd1, 32'h0000_00a4, 3, 0, none));
    stim_rows.push_back(row(OP_INSERT, 32'sh4000_0000, 32'h8000_00a5, 0, 0, none));
    stim_rows.push_back(row(OP_INSERT, 32'shc000_0000, 32'h0000_00a6, 12, 0, none));
    stim_rows.push_back(row(OP_INSERT, 32'sd100, 32'h0000_00a7, 0, 0, none));
    stim_rows.push_back(row(OP_INSERT, 32'sd0, 32'h0000_00a8, 5, 0, none));
    stim_rows.push_back(row(OP_INSERT, SCORE_MIN, 32'h0000_00a9, 0, 1, rejected));
    stim_rows.push_back(row(OP_INSERT, SCORE_MIN + 32'sd1, 32'h0000_00aa, 0, 0, none));
    stim_rows.push_back(row(OP_INSERT, SCORE_MIN + 32'sd1, 32'h0000_00ab, 0, 1, rejected));
    stim_rows.push_back(row(OP_INSERT, SCORE_MIN, 32'h0000_00ac, 9, 1, rejected));
    stim_rows.push_back(row(OP_READ, 32'sh0, 32'h0, 9, 0, none));
    stim_rows.push_back(row(OP_READ, 32'sh0, 32'h0, 10, 1, rejected));
    stim_rows.push_back(row(OP_READ, SCORE_MAX, 32'hffff_ffff, 15, 1, rejected));
    stim_rows.push_back(row(OP_INSERT, SCORE_MAX, 32'h0000_00ad, 0, 0, none));
    stim_rows.push_back(row(OP_READ, 32'sh0, 32'h0, 0, 0, none));
    stim_rows.push_back(row(OP_READ, 32'sh0, 32'h0, 1, 0, none));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i])
      send_word(stim_rows[i].w, stim_rows[i].typed, stim_rows[i].want, 1'b1);

    // words 500 to 799 go back to back
    for (int n = 0; n < RANDOM_WORDS; n++)
      send_word(random_word(), 1'b0, none, (n < 500 || n >= 800));

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tkst_pkg.sv
rtl/core/tkst_mem.sv
rtl/core/tkst_ctrl.sv
rtl/core/top_k_sorted_insert_table.sv
rtl/core/tkst_chk.sv
test/tb_top_k_sorted_insert_table.sv
